// ----- rtl/rrs_pkg.sv -----
package rrs_pkg;

	localparam int DV1_STEPS = 30;
	localparam int DV2_STEPS = 64;
	localparam int SQ_STEPS  = 32;

	localparam logic [2:0] REG_SCREEN_WIDTH = 3'd0;
	localparam logic [2:0] REG_DIR_X        = 3'd1;
	localparam logic [2:0] REG_DIR_Y        = 3'd2;
	localparam logic [2:0] REG_PLANE_X      = 3'd3;
	localparam logic [2:0] REG_PLANE_Y      = 3'd4;
	localparam logic [2:0] REG_POS_X        = 3'd5;
	localparam logic [2:0] REG_POS_Y        = 3'd6;

	// rounding divide of |plane*off| by the width
	typedef struct packed {
		logic [13:0] rem;
		logic [29:0] nq;
		logic [13:0] d;
		logic        neg;
	} dv1_t;

	// (a^2+b^2)<<32 / a^2
	typedef struct packed {
		logic [30:0] rem;
		logic [63:0] nq;
		logic [30:0] d;
	} dv2_t;

	typedef struct packed {
		logic [63:0] n;
		logic [35:0] rem;
		logic [31:0] root;
	} sq_t;

	function automatic dv1_t dv1_step(dv1_t x);
		logic [14:0] t;
		dv1_t        y;
		y = x;
		t = {x.rem, x.nq[29]};
		if (t >= {1'b0, x.d}) begin
			t = t - {1'b0, x.d};
			y.nq = {x.nq[28:0], 1'b1};
		end else begin
			y.nq = {x.nq[28:0], 1'b0};
		end
		y.rem = t[13:0];
		return y;
	endfunction

	function automatic dv2_t dv2_step(dv2_t x);
		logic [31:0] t;
		dv2_t        y;
		y = x;
		t = {x.rem, x.nq[63]};
		if (t >= {1'b0, x.d}) begin
			t = t - {1'b0, x.d};
			y.nq = {x.nq[62:0], 1'b1};
		end else begin
			y.nq = {x.nq[62:0], 1'b0};
		end
		y.rem = t[30:0];
		return y;
	endfunction

	function automatic sq_t sq_step(sq_t x);
		logic [35:0] t;
		logic [35:0] trial;
		sq_t         y;
		y = x;
		t = {x.rem[33:0], x.n[63:62]};
		trial = {2'b00, x.root, 2'b01};
		if (t >= trial) begin
			y.rem = t - trial;
			y.root = {x.root[30:0], 1'b1};
		end else begin
			y.rem = t;
			y.root = {x.root[30:0], 1'b0};
		end
		y.n = {x.n[61:0], 2'b00};
		return y;
	endfunction

endpackage

// ----- rtl/raycast_ray_setup.sv -----
// Ray setup for one screen column of a grid-stepping raycaster.
// Input stream s_*: one column index per transaction (tdata[11:0]).
// Output stream m_*: one transaction per column, tdata from bit 0 up:
//   ray_dir_x[15:0], ray_dir_y[15:0], cell_x[9:0], cell_y[9:0],
//   delta_x[31:0] (Q16.16), delta_y[31:0] (Q16.16), 4 zero bits.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// index 0 screen_width, 1..4 dir/plane x,y, 5..6 pos x,y. Write only while
// no column is in flight.
// Stages: input and product stages, a 30-step rounding divider, ray
// saturation, squaring, a 64-step divider and a 32-step square root,
// one bit (or bit pair) per stage.
// Throughput is one column per cycle unless the output stalls; every stage is registered.
// Reset clears the valid bits and loads the default camera registers.
// When m_tready is low with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
module raycast_ray_setup #(
	parameter int MAX_COLUMNS = 4096,
	parameter int MAP_CELLS   = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // column[11:0], zeros
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // ray_dir_x, ray_dir_y, cell_x, cell_y, delta_x, delta_y
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [21:0]  cfg_data
);

	localparam int DV1 = rrs_pkg::DV1_STEPS;
	localparam int DV2 = rrs_pkg::DV2_STEPS;
	localparam int SQ  = rrs_pkg::SQ_STEPS;
	localparam int LAT = 4 + DV1 + DV2 + SQ;
	localparam int I4  = 2 + DV1;
	localparam int I5  = 3 + DV1;

	logic [12:0]        width_q;
	logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [21:0]        pos_x_q, pos_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 13'd640;
			dir_x_q   <= -16'sd4096;
			dir_y_q   <= 16'sd0;
			plane_x_q <= 16'sd0;
			plane_y_q <= 16'sd2703;
			pos_x_q   <= 22'd0;
			pos_y_q   <= 22'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rrs_pkg::REG_SCREEN_WIDTH: width_q   <= cfg_data[12:0];
				rrs_pkg::REG_DIR_X:        dir_x_q   <= cfg_data[15:0];
				rrs_pkg::REG_DIR_Y:        dir_y_q   <= cfg_data[15:0];
				rrs_pkg::REG_PLANE_X:      plane_x_q <= cfg_data[15:0];
				rrs_pkg::REG_PLANE_Y:      plane_y_q <= cfg_data[15:0];
				rrs_pkg::REG_POS_X:        pos_x_q   <= cfg_data;
				rrs_pkg::REG_POS_Y:        pos_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [LAT-1:0] vld_q;
	logic           en;

	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// stage 1: clamp column, offset 2*col - w
	logic [11:0]        col_c;
	logic [12:0]        w_eff;
	logic signed [14:0] off_s1;
	logic [12:0]        w_s1;

	always_comb begin
		col_c = s_tdata[11:0];
		if (int'(col_c) > MAX_COLUMNS - 1)
			col_c = 12'(MAX_COLUMNS - 1);
		w_eff = (width_q == 13'd0) ? 13'd1 : width_q;
	end

	// stage 2: product, magnitude, rounding dividend
	logic signed [30:0] prod [2];
	logic [29:0]        mag  [2];
	rrs_pkg::dv1_t      init1 [2];

	always_comb begin
		prod[0] = 31'(plane_x_q * off_s1);
		prod[1] = 31'(plane_y_q * off_s1);
		for (int l = 0; l < 2; l++) begin
			mag[l] = prod[l][30] ? 30'(-prod[l]) : 30'(prod[l]);
			init1[l].rem = '0;
			init1[l].nq  = {mag[l][28:0], 1'b0} + {17'd0, w_s1};
			init1[l].d   = {w_s1, 1'b0};
			init1[l].neg = prod[l][30];
		end
	end

	rrs_pkg::dv1_t dv1_s2 [2];
	rrs_pkg::dv1_t dv1_s3 [DV1][2];

	// stage 4: dir + rounded term, saturated
	logic signed [15:0] ray_s4 [2];
	logic signed [31:0] sum4   [2];
	logic signed [15:0] dirs   [2];

	always_comb begin
		dirs[0] = dir_x_q;
		dirs[1] = dir_y_q;
		for (int l = 0; l < 2; l++) begin
			if (dv1_s3[DV1-1][l].neg)
				sum4[l] = 32'(dirs[l]) - $signed({2'b00, dv1_s3[DV1-1][l].nq});
			else
				sum4[l] = 32'(dirs[l]) + $signed({2'b00, dv1_s3[DV1-1][l].nq});
		end
	end

	// stage 5: squares
	logic [30:0]        sq_s5  [2];
	logic signed [15:0] ray_s5 [2];

	logic [31:0]   sqsum;
	rrs_pkg::dv2_t init2 [2];

	always_comb begin
		sqsum = {1'b0, sq_s5[0]} + {1'b0, sq_s5[1]};
		for (int l = 0; l < 2; l++) begin
			init2[l].rem = '0;
			init2[l].nq  = {sqsum, 32'd0};
			init2[l].d   = sq_s5[l];
		end
	end

	rrs_pkg::dv2_t      dv2_s6 [DV2][2];
	logic signed [15:0] ray_s6 [DV2][2];
	rrs_pkg::sq_t       sq_s7  [SQ][2];
	logic signed [15:0] ray_s7 [SQ][2];

	rrs_pkg::sq_t init3 [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			init3[l].n    = dv2_s6[DV2-1][l].nq;
			init3[l].rem  = '0;
			init3[l].root = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s1 <= $signed({2'b00, col_c, 1'b0}) - $signed({2'b00, w_eff});
			w_s1   <= w_eff;
			for (int l = 0; l < 2; l++) begin
				dv1_s2[l]    <= init1[l];
				dv1_s3[0][l] <= rrs_pkg::dv1_step(dv1_s2[l]);
				for (int i = 1; i < DV1; i++)
					dv1_s3[i][l] <= rrs_pkg::dv1_step(dv1_s3[i-1][l]);
				if (sum4[l] > 32'sd32767)
					ray_s4[l] <= 16'sh7FFF;
				else if (sum4[l] < -32'sd32768)
					ray_s4[l] <= -16'sh8000;
				else
					ray_s4[l] <= sum4[l][15:0];
				sq_s5[l]  <= 31'(ray_s4[l] * ray_s4[l]);
				ray_s5[l] <= ray_s4[l];
				dv2_s6[0][l] <= rrs_pkg::dv2_step(init2[l]);
				ray_s6[0][l] <= ray_s5[l];
				for (int i = 1; i < DV2; i++) begin
					dv2_s6[i][l] <= rrs_pkg::dv2_step(dv2_s6[i-1][l]);
					ray_s6[i][l] <= ray_s6[i-1][l];
				end
				sq_s7[0][l]  <= rrs_pkg::sq_step(init3[l]);
				ray_s7[0][l] <= ray_s6[DV2-1][l];
				for (int i = 1; i < SQ; i++) begin
					sq_s7[i][l]  <= rrs_pkg::sq_step(sq_s7[i-1][l]);
					ray_s7[i][l] <= ray_s7[i-1][l];
				end
			end
		end
	end

	// output assembly
	logic signed [15:0] rx, ry;
	logic [31:0]        delta_x, delta_y;
	logic [9:0]         cell_x, cell_y;

	function automatic logic [9:0] cell_of(logic [21:0] pos);
		logic [9:0] c;
		c = pos[21:12];
		if (int'(c) > MAP_CELLS - 1)
			c = 10'(MAP_CELLS - 1);
		return c;
	endfunction

	always_comb begin
		rx = ray_s7[SQ-1][0];
		ry = ray_s7[SQ-1][1];
		if (ry == 16'sd0)
			delta_x = 32'd0;
		else if (rx == 16'sd0)
			delta_x = 32'd65536;
		else
			delta_x = sq_s7[SQ-1][0].root;
		if (rx == 16'sd0)
			delta_y = 32'd0;
		else if (ry == 16'sd0)
			delta_y = 32'd65536;
		else
			delta_y = sq_s7[SQ-1][1].root;
		cell_x = cell_of(pos_x_q);
		cell_y = cell_of(pos_y_q);
	end

	assign m_tdata = {4'd0, delta_y, delta_x, cell_y, cell_x, ry, rx};

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while output stalled");

	a_ray_y_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[31:16] == 16'd0) |-> m_tdata[83:52] == 32'd0)
		else $error("delta_x not zero for zero ray_dir_y");

	a_ray_x_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[15:0] == 16'd0 && m_tdata[31:16] != 16'd0)
		|-> m_tdata[83:52] == 32'd65536)
		else $error("delta_x not one for zero ray_dir_x");

	a_valid_ray_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[I4]) |=> vld_q[I5])
		else $error("valid lost between ray and square stages");

endmodule

// ----- dv/raycast_ray_setup_tb.sv -----
module raycast_ray_setup_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int PIPE_LAT = 130;
	localparam int N_RANDOM = 1880;

	typedef struct {
		logic signed [15:0] rdx;
		logic signed [15:0] rdy;
		logic [9:0]         cx;
		logic [9:0]         cy;
		logic [31:0]        dlx;
		logic [31:0]        dly;
	} ray_t;

	typedef struct {
		logic [11:0] col;
		bit          typed;
		ray_t        ray;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b1;
	logic [119:0] m_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [21:0]  cfg_data = '0;

	// shadow copy of the camera registers
	logic [12:0] sh_width = 13'd640;
	logic [15:0] sh_dir_x = 16'hF000;
	logic [15:0] sh_dir_y = '0;
	logic [15:0] sh_plane_x = '0;
	logic [15:0] sh_plane_y = 16'd2703;
	logic [21:0] sh_pos_x = '0;
	logic [21:0] sh_pos_y = '0;

	ray_t pending_rays[$];
	int   errors = 0;
	bit   quiet = 1'b0;

	raycast_ray_setup DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // column[11:0], zeros
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // ray_dir_x, ray_dir_y, cell_x, cell_y, delta_x, delta_y
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint steer(longint d, longint p, longint off, longint w);
		longint num, mag, q, s;
		num = p * off;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + w) / (2 * w);
		s = (num < 0) ? d - q : d + q;
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		return s;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] res, b;
		res = '0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// step length along an axis: own component a, other component b
	function automatic logic [31:0] step_len(longint a, longint b);
		logic [63:0] a2, b2, r;
		if (b == 0)
			return 32'd0;
		if (a == 0)
			return 32'd65536;
		a2 = a * a;
		b2 = b * b;
		r = int_sqrt(((a2 + b2) << 32) / a2);
		if (r > 64'hFFFF_FFFF)
			r = 64'hFFFF_FFFF;
		return r[31:0];
	endfunction

	function automatic ray_t predict_ray(logic [11:0] col);
		ray_t   r;
		longint w, off, rx, ry;
		w = (sh_width == 0) ? 1 : longint'(sh_width);
		off = 2 * longint'(col) - w;
		rx = steer(longint'($signed(sh_dir_x)), longint'($signed(sh_plane_x)), off, w);
		ry = steer(longint'($signed(sh_dir_y)), longint'($signed(sh_plane_y)), off, w);
		r.rdx = rx[15:0];
		r.rdy = ry[15:0];
		r.cx = sh_pos_x[21:12];
		r.cy = sh_pos_y[21:12];
		r.dlx = step_len(rx, ry);
		r.dly = step_len(ry, rx);
		return r;
	endfunction

	task automatic cfg_write(logic [2:0] idx, logic [21:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			rrs_pkg::REG_SCREEN_WIDTH: sh_width = val[12:0];
			rrs_pkg::REG_DIR_X:        sh_dir_x = val[15:0];
			rrs_pkg::REG_DIR_Y:        sh_dir_y = val[15:0];
			rrs_pkg::REG_PLANE_X:      sh_plane_x = val[15:0];
			rrs_pkg::REG_PLANE_Y:      sh_plane_y = val[15:0];
			rrs_pkg::REG_POS_X:        sh_pos_x = val;
			rrs_pkg::REG_POS_Y:        sh_pos_y = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		while (pending_rays.size() != 0)
			@(negedge clk);
		repeat (PIPE_LAT + 10) @(negedge clk);
	endtask

	task automatic send_column(logic [11:0] col, ray_t exp_ray);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {4'b0, col};
		do
			@(posedge clk);
		while (!s_tready);
		pending_rays.push_back(exp_ray);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		ray_t e;
		if (m_tvalid && m_tready) begin
			if (pending_rays.size() == 0) begin
				errors++;
				$display("%0t unexpected transaction: expected none actual %h", $time, m_tdata);
			end else begin
				e = pending_rays.pop_front();
				check_field("ray_dir_x", {16'd0, e.rdx}, 32'(m_tdata[15:0]));
				check_field("ray_dir_y", {16'd0, e.rdy}, 32'(m_tdata[31:16]));
				check_field("cell_x", 32'(e.cx), 32'(m_tdata[41:32]));
				check_field("cell_y", 32'(e.cy), 32'(m_tdata[51:42]));
				check_field("delta_x", e.dlx, m_tdata[83:52]);
				check_field("delta_y", e.dly, m_tdata[115:84]);
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				m_tready = 1'b1;
			end
		end
	end

	function automatic logic [21:0] rand_axis();
		case ($urandom_range(0, 7))
			0:       return 22'd0;
			1, 2:    return 22'($signed(16'($urandom_range(0, 16383)) - 16'sd8192));
			default: return 22'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		row_t       dir_rows[9];
		int         cols[3];
		logic [21:0] w_rand;
		logic [11:0] col;
		ray_t        r;

		dir_rows[0] = '{12'd320, 1'b1, '{-16'sd4096, 16'sd0, 10'd0, 10'd0, 32'd0, 32'd65536}};
		dir_rows[1] = '{12'd0, 1'b0, '{default: '0}};
		dir_rows[2] = '{12'd4095, 1'b0, '{default: '0}};
		dir_rows[3] = '{12'd1, 1'b0, '{default: '0}};
		dir_rows[4] = '{12'd639, 1'b0, '{default: '0}};
		dir_rows[5] = '{12'd640, 1'b0, '{default: '0}};
		dir_rows[6] = '{12'd2048, 1'b0, '{default: '0}};
		dir_rows[7] = '{12'hAAA, 1'b0, '{default: '0}};
		dir_rows[8] = '{12'h555, 1'b0, '{default: '0}};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_rows[i])
			send_column(dir_rows[i].col,
				dir_rows[i].typed ? dir_rows[i].ray : predict_ray(dir_rows[i].col));

		// extreme camera settings
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: begin
					cfg_write(rrs_pkg::REG_SCREEN_WIDTH, 22'd1);
					cfg_write(rrs_pkg::REG_DIR_X, 22'h7FFF);
					cfg_write(rrs_pkg::REG_DIR_Y, 22'h7FFF);
					cfg_write(rrs_pkg::REG_PLANE_X, 22'h7FFF);
					cfg_write(rrs_pkg::REG_PLANE_Y, 22'h8000);
					cfg_write(rrs_pkg::REG_POS_X, 22'h3FFFFF);
					cfg_write(rrs_pkg::REG_POS_Y, 22'h3FFFFF);
				end
				1: begin
					// width zero acts as one
					cfg_write(rrs_pkg::REG_SCREEN_WIDTH, 22'd0);
					cfg_write(rrs_pkg::REG_DIR_X, 22'h8000);
					cfg_write(rrs_pkg::REG_DIR_Y, 22'h8000);
					cfg_write(rrs_pkg::REG_PLANE_X, 22'h8000);
					cfg_write(rrs_pkg::REG_PLANE_Y, 22'h7FFF);
				end
				2: begin
					cfg_write(rrs_pkg::REG_SCREEN_WIDTH, 22'd8191);
					cfg_write(rrs_pkg::REG_DIR_X, 22'd0);
					cfg_write(rrs_pkg::REG_DIR_Y, 22'd0);
					cfg_write(rrs_pkg::REG_PLANE_X, 22'd0);
					cfg_write(rrs_pkg::REG_PLANE_Y, 22'd0);
					cfg_write(rrs_pkg::REG_POS_X, 22'd0);
				end
				3: begin
					cfg_write(rrs_pkg::REG_SCREEN_WIDTH, 22'd4096);
					cfg_write(rrs_pkg::REG_DIR_Y, 22'd4096);
					cfg_write(rrs_pkg::REG_PLANE_X, 22'd2703);
					cfg_write(rrs_pkg::REG_POS_X, 22'h234567);
					cfg_write(rrs_pkg::REG_POS_Y, 22'h1ABCDE);
				end
				default: begin
					// unknown index must leave everything alone
					cfg_write(REG_UNUSED, 22'h3FFFFF);
					cfg_write(rrs_pkg::REG_SCREEN_WIDTH, 22'hFFFFF);
				end
			endcase
			cols[0] = 0;
			cols[1] = sh_width / 2;
			cols[2] = 4095;
			foreach (cols[k])
				send_column(12'(cols[k]), predict_ray(12'(cols[k])));
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 170 == 0) begin
				drain();
				case ($urandom_range(0, 9))
					0:       w_rand = 22'($urandom_range(0, 8191));
					1:       w_rand = 22'($urandom_range(1, 4));
					default: w_rand = 22'($urandom_range(1, 4096));
				endcase
				cfg_write(rrs_pkg::REG_SCREEN_WIDTH, w_rand);
				cfg_write(rrs_pkg::REG_DIR_X, rand_axis());
				cfg_write(rrs_pkg::REG_DIR_Y, rand_axis());
				cfg_write(rrs_pkg::REG_PLANE_X, rand_axis());
				cfg_write(rrs_pkg::REG_PLANE_Y, rand_axis());
				cfg_write(rrs_pkg::REG_POS_X, 22'($urandom));
				cfg_write(rrs_pkg::REG_POS_Y, 22'($urandom));
			end
			if (n == 600) begin
				while (pending_rays.size() != 0)
					@(negedge clk);
			end
			if (n == N_RANDOM - 300)
				quiet = 1'b1;
			if ($urandom_range(0, 3) == 0 || sh_width == 0)
				col = 12'($urandom);
			else
				col = 12'($urandom_range(0, (sh_width > 4096 ? 4096 : sh_width) - 1));
			send_column(col, predict_ray(col));
		end

		while (pending_rays.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 20) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#6ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
